### design/otwdm_pkg.sv
// Shared types, constants and lookup tables for the three-wheel omni drive mixer.
`timescale 1ns / 1ps
`default_nettype none
package otwdm_pkg;

   // Field widths
   localparam int SPEED_W    = 11;
   localparam int HEAD_W     = 10;
   localparam int POS_W      = 16;
   localparam int BOUND_W    = 16;
   localparam int WHEEL_W    = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Internal widths
   localparam int SIN_W    = 17;   // Q1.15 sine with room for +1.0
   localparam int ROT_W    = 28;   // rotated speed, 15 fraction bits
   localparam int DIFF_W   = 17;   // bound minus position
   localparam int LIM_W    = 35;   // bound distance scaled into speed units
   localparam int NUM_W    = 46;   // wheel numerator
   localparam int GAIN_W   = 15;   // soft-start gain, Q0.15
   localparam int PROD_W   = 61;   // numerator times gain
   localparam int DIV_SHIFT = 46;  // wheel = product / (3 * 2^46)
   localparam int QUOT_W   = PROD_W - DIV_SHIFT;
   localparam int W_W      = 13;   // quotient by 2^46 below saturation
   localparam int RECIP_W  = 16;
   localparam int RECIP3_SHIFT = 17;
   localparam int DQ_W     = W_W + RECIP_W;
   localparam int STEP_W   = 6;
   localparam int WHEELS   = 3;
   localparam int HP_W     = 12;

   localparam int ROT_CNT_W = $clog2(SPEED_W);
   localparam int MUL_CNT_W = $clog2(GAIN_W);

   localparam logic [STEP_W-1:0] RAMP_STEPS = STEP_W'(50);

   localparam int Q15_SHIFT = 15;
   localparam int NUM_SHIFT = 16;
   localparam logic signed [SIN_W-1:0]  Q15_ONE        = 17'sd32768;
   localparam logic signed [ROT_W-1:0]  SPEED_HALF     = 28'sd16384;
   localparam logic signed [ROT_W-1:0]  SPEED_HALF_NEG = -28'sd16384;
   localparam logic signed [SPEED_W-1:0] TURN_DEAD     = 11'sd5;
   localparam logic signed [SPEED_W-1:0] TURN_DEAD_NEG = -11'sd5;
   // 3 * round(2^16 * sqrt(3)/3)
   localparam logic signed [NUM_W-1:0]  YK_SCALE       = 46'sd113511;
   localparam logic [PROD_W-1:0]        HALF_DIV       = PROD_W'(3) << (DIV_SHIFT - 1);
   localparam logic [QUOT_W-1:0]        SAT_QUOT       = QUOT_W'(6144);
   localparam logic [RECIP_W-1:0]       RECIP3         = 16'd43691;
   localparam logic signed [WHEEL_W-1:0] WHEEL_MAX     = 12'sd2047;
   localparam logic signed [WHEEL_W-1:0] WHEEL_MIN     = -12'sd2048;

   localparam logic signed [HP_W-1:0] HEAD_BIAS = 12'sd720;
   localparam logic signed [HP_W-1:0] DEG_1080  = 12'sd1080;
   localparam logic signed [HP_W-1:0] DEG_720   = 12'sd720;
   localparam logic signed [HP_W-1:0] DEG_360   = 12'sd360;

   // Reset values of the bounds
   localparam logic signed [BOUND_W-1:0] X_LO_RESET = -16'sd444;
   localparam logic signed [BOUND_W-1:0] X_HI_RESET = 16'sd14830;
   localparam logic signed [BOUND_W-1:0] Y_LO_RESET = -16'sd503;
   localparam logic signed [BOUND_W-1:0] Y_HI_RESET = 16'sd10038;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_ORIENTED = 3'd0,
      CSR_X_LOWER        = 3'd1,
      CSR_X_UPPER        = 3'd2,
      CSR_Y_LOWER        = 3'd3,
      CSR_Y_UPPER        = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_ROT,
      S_JUDGE,
      S_NUM,
      S_MUL,
      S_RND,
      S_DIV,
      S_DONE
   } state_type;

   // round(2^15 * sin(i deg)), i = 0..90
   function automatic logic [15:0] sin_quarter(input logic [6:0] i);
      logic [15:0] v;
      case (i)
         7'd0: v = 16'd0;         7'd1: v = 16'd572;       7'd2: v = 16'd1144;
         7'd3: v = 16'd1715;      7'd4: v = 16'd2286;      7'd5: v = 16'd2856;
         7'd6: v = 16'd3425;      7'd7: v = 16'd3993;      7'd8: v = 16'd4560;
         7'd9: v = 16'd5126;      7'd10: v = 16'd5690;     7'd11: v = 16'd6252;
         7'd12: v = 16'd6813;     7'd13: v = 16'd7371;     7'd14: v = 16'd7927;
         7'd15: v = 16'd8481;     7'd16: v = 16'd9032;     7'd17: v = 16'd9580;
         7'd18: v = 16'd10126;    7'd19: v = 16'd10668;    7'd20: v = 16'd11207;
         7'd21: v = 16'd11743;    7'd22: v = 16'd12275;    7'd23: v = 16'd12803;
         7'd24: v = 16'd13328;    7'd25: v = 16'd13848;    7'd26: v = 16'd14365;
         7'd27: v = 16'd14876;    7'd28: v = 16'd15384;    7'd29: v = 16'd15886;
         7'd30: v = 16'd16384;    7'd31: v = 16'd16877;    7'd32: v = 16'd17364;
         7'd33: v = 16'd17847;    7'd34: v = 16'd18324;    7'd35: v = 16'd18795;
         7'd36: v = 16'd19261;    7'd37: v = 16'd19720;    7'd38: v = 16'd20174;
         7'd39: v = 16'd20622;    7'd40: v = 16'd21063;    7'd41: v = 16'd21498;
         7'd42: v = 16'd21926;    7'd43: v = 16'd22348;    7'd44: v = 16'd22763;
         7'd45: v = 16'd23170;    7'd46: v = 16'd23571;    7'd47: v = 16'd23965;
         7'd48: v = 16'd24351;    7'd49: v = 16'd24730;    7'd50: v = 16'd25102;
         7'd51: v = 16'd25466;    7'd52: v = 16'd25822;    7'd53: v = 16'd26170;
         7'd54: v = 16'd26510;    7'd55: v = 16'd26842;    7'd56: v = 16'd27166;
         7'd57: v = 16'd27482;    7'd58: v = 16'd27789;    7'd59: v = 16'd28088;
         7'd60: v = 16'd28378;    7'd61: v = 16'd28660;    7'd62: v = 16'd28932;
         7'd63: v = 16'd29197;    7'd64: v = 16'd29452;    7'd65: v = 16'd29698;
         7'd66: v = 16'd29935;    7'd67: v = 16'd30163;    7'd68: v = 16'd30382;
         7'd69: v = 16'd30592;    7'd70: v = 16'd30792;    7'd71: v = 16'd30983;
         7'd72: v = 16'd31164;    7'd73: v = 16'd31336;    7'd74: v = 16'd31499;
         7'd75: v = 16'd31651;    7'd76: v = 16'd31795;    7'd77: v = 16'd31928;
         7'd78: v = 16'd32052;    7'd79: v = 16'd32166;    7'd80: v = 16'd32270;
         7'd81: v = 16'd32365;    7'd82: v = 16'd32449;    7'd83: v = 16'd32524;
         7'd84: v = 16'd32588;    7'd85: v = 16'd32643;    7'd86: v = 16'd32688;
         7'd87: v = 16'd32723;    7'd88: v = 16'd32748;    7'd89: v = 16'd32763;
         7'd90: v = 16'd32768;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // Sine of a whole-degree angle in 0..359, Q1.15
   function automatic logic signed [SIN_W-1:0] sin_deg(input logic [8:0] d);
      logic [6:0]  idx;
      logic        neg;
      logic signed [SIN_W-1:0] mag;
      if (d <= 9'd90) begin
         idx = d[6:0];
         neg = 1'b0;
      end else if (d <= 9'd180) begin
         idx = 7'(9'd180 - d);
         neg = 1'b0;
      end else if (d <= 9'd270) begin
         idx = 7'(d - 9'd180);
         neg = 1'b1;
      end else begin
         idx = 7'(9'd360 - d);
         neg = 1'b1;
      end
      mag = signed'({1'b0, sin_quarter(idx)});
      return neg ? -mag : mag;
   endfunction

   // Sigmoid soft-start gain, one entry per ramp step (table spans 0..RAMP_STEPS)
   function automatic logic [GAIN_W-1:0] ramp_gain(input logic [STEP_W-1:0] step);
      logic [GAIN_W-1:0] g;
      case (step)
         6'd0: g = 15'd2486;    6'd1: g = 15'd2725;    6'd2: g = 15'd2986;
         6'd3: g = 15'd3269;    6'd4: g = 15'd3575;    6'd5: g = 15'd3906;
         6'd6: g = 15'd4263;    6'd7: g = 15'd4648;    6'd8: g = 15'd5062;
         6'd9: g = 15'd5504;    6'd10: g = 15'd5978;   6'd11: g = 15'd6482;
         6'd12: g = 15'd7018;   6'd13: g = 15'd7585;   6'd14: g = 15'd8183;
         6'd15: g = 15'd8813;   6'd16: g = 15'd9472;   6'd17: g = 15'd10159;
         6'd18: g = 15'd10873;  6'd19: g = 15'd11611;  6'd20: g = 15'd12371;
         6'd21: g = 15'd13150;  6'd22: g = 15'd13945;  6'd23: g = 15'd14751;
         6'd24: g = 15'd15565;  6'd25: g = 15'd16384;  6'd26: g = 15'd17203;
         6'd27: g = 15'd18017;  6'd28: g = 15'd18823;  6'd29: g = 15'd19618;
         6'd30: g = 15'd20397;  6'd31: g = 15'd21157;  6'd32: g = 15'd21895;
         6'd33: g = 15'd22609;  6'd34: g = 15'd23296;  6'd35: g = 15'd23955;
         6'd36: g = 15'd24585;  6'd37: g = 15'd25183;  6'd38: g = 15'd25750;
         6'd39: g = 15'd26286;  6'd40: g = 15'd26790;  6'd41: g = 15'd27264;
         6'd42: g = 15'd27706;  6'd43: g = 15'd28120;  6'd44: g = 15'd28505;
         6'd45: g = 15'd28862;  6'd46: g = 15'd29193;  6'd47: g = 15'd29499;
         6'd48: g = 15'd29782;  6'd49: g = 15'd30043;
         default: g = 15'd30282;
      endcase
      return g;
   endfunction

   // diff * 102400, with 102400 = 2^16 + 2^15 + 2^12
   function automatic logic signed [LIM_W-1:0] bound_limit(
      input logic signed [DIFF_W-1:0] diff);
      logic signed [LIM_W-1:0] ext;
      ext = LIM_W'(diff);
      return (ext <<< 16) + (ext <<< 15) + (ext <<< 12);
   endfunction

endpackage
`default_nettype wire

### design/otwdm_if.sv
// Handshake channel interfaces: command words, wheel words and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface otwdm_req_if;
   logic valid;
   logic ready;
   logic signed [otwdm_pkg::SPEED_W-1:0] speed_x;
   logic signed [otwdm_pkg::SPEED_W-1:0] speed_y;
   logic signed [otwdm_pkg::SPEED_W-1:0] speed_turn;
   logic signed [otwdm_pkg::HEAD_W-1:0]  heading_deg;
   logic signed [otwdm_pkg::POS_W-1:0]   pos_x;
   logic signed [otwdm_pkg::POS_W-1:0]   pos_y;

   modport source (output valid, speed_x, speed_y, speed_turn, heading_deg, pos_x, pos_y,
                   input ready);
   modport sink (input valid, speed_x, speed_y, speed_turn, heading_deg, pos_x, pos_y,
                 output ready);
endinterface

interface otwdm_rsp_if;
   logic valid;
   logic ready;
   logic signed [otwdm_pkg::WHEEL_W-1:0] wheel_a;
   logic signed [otwdm_pkg::WHEEL_W-1:0] wheel_b;
   logic signed [otwdm_pkg::WHEEL_W-1:0] wheel_c;
   logic                                 stopped;

   modport source (output valid, wheel_a, wheel_b, wheel_c, stopped, input ready);
   modport sink (input valid, wheel_a, wheel_b, wheel_c, stopped, output ready);
endinterface

interface otwdm_csr_if;
   logic valid;
   logic ready;
   logic [otwdm_pkg::CSR_IDX_W-1:0]  index;
   logic [otwdm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/omni_three_wheel_drive_mixer.sv
// Top level of the three-wheel omni drive mixer: registers, sequencer and output word.
// Sequence: PREP, ROT (bit-serial rotator), JUDGE, NUM, MUL (bit-serial gain multiplier),
//   RND, DIV, DONE; a near-zero command skips the mixing steps from JUDGE to DONE.
// A new command is accepted only in IDLE, after the last wheel word has been loaded
//   into the output register.
// Reset: synchronous, active high; clears the sequencer, the ramp step, the output valid
//   and sets the registers to field_oriented 0 and the default field bounds.
`timescale 1ns / 1ps
`default_nettype none
module omni_three_wheel_drive_mixer (
   input logic clock,
   input logic reset,
   otwdm_req_if.sink   req_if,
   otwdm_rsp_if.source rsp_if,
   otwdm_csr_if.sink   csr_if
);

   // ---------------------------------------------------------------- registers
   logic                                    field_ff;
   logic signed [otwdm_pkg::BOUND_W-1:0]    xlo_ff, xhi_ff, ylo_ff, yhi_ff;

   otwdm_pkg::state_type                    state_ff, state_in;
   logic [otwdm_pkg::STEP_W-1:0]            step_ff, step_in;

   logic signed [otwdm_pkg::SPEED_W-1:0]    cx_ff, cy_ff, t_ff;
   logic signed [otwdm_pkg::HEAD_W-1:0]     h_ff;
   logic signed [otwdm_pkg::DIFF_W-1:0]     dxlo_ff, dxhi_ff, dylo_ff, dyhi_ff;
   logic signed [otwdm_pkg::LIM_W-1:0]      limxlo_ff, limxhi_ff, limylo_ff, limyhi_ff;
   logic                                    xz_ff, yz_ff;
   logic signed [otwdm_pkg::NUM_W-1:0]      yk_ff;
   logic signed [otwdm_pkg::WHEEL_W-1:0]    res_ff [otwdm_pkg::WHEELS];
   logic                                    res_stop_ff;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [otwdm_pkg::WHEEL_W-1:0]    out_ff [otwdm_pkg::WHEELS];
   logic                                    out_stop_ff;

   // ---------------------------------------------------------------- handshakes
   logic req_acc, csr_acc, out_free;

   assign req_if.ready = state_ff == otwdm_pkg::S_IDLE;
   assign req_acc      = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign csr_acc      = csr_if.valid && csr_if.ready;
   // the output word may be replaced when empty or taken this cycle
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.wheel_a = out_ff[0];
   assign rsp_if.wheel_b = out_ff[1];
   assign rsp_if.wheel_c = out_ff[2];
   assign rsp_if.stopped = out_stop_ff;

   // ---------------------------------------------------------------- sequencer outputs
   logic rot_start, mul_start, rnd_take, load_res, load_out, judge;
   logic rot_done, mul_done;

   always_comb begin
      rot_start = 1'b0;
      mul_start = 1'b0;
      rnd_take  = 1'b0;
      load_res  = 1'b0;
      load_out  = 1'b0;
      judge     = 1'b0;
      case (state_ff)
         otwdm_pkg::S_PREP:  rot_start = 1'b1;
         otwdm_pkg::S_JUDGE: judge     = 1'b1;
         otwdm_pkg::S_NUM:   mul_start = 1'b1;
         otwdm_pkg::S_RND:   rnd_take  = 1'b1;
         otwdm_pkg::S_DIV:   load_res  = 1'b1;
         otwdm_pkg::S_DONE:  load_out  = out_free;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- heading and sines
   logic signed [otwdm_pkg::HP_W-1:0]   hp;
   logic [8:0]                          dsin, dcos;
   logic [9:0]                          dq;
   logic signed [otwdm_pkg::SIN_W-1:0]  cs_sel, sn_sel;

   always_comb begin
      // fold any heading into 0..359
      hp = otwdm_pkg::HP_W'(h_ff) + otwdm_pkg::HEAD_BIAS;
      if (hp >= otwdm_pkg::DEG_1080) begin
         dsin = 9'(hp - otwdm_pkg::DEG_1080);
      end else if (hp >= otwdm_pkg::DEG_720) begin
         dsin = 9'(hp - otwdm_pkg::DEG_720);
      end else if (hp >= otwdm_pkg::DEG_360) begin
         dsin = 9'(hp - otwdm_pkg::DEG_360);
      end else begin
         dsin = hp[8:0];
      end
      dq   = {1'b0, dsin} + 10'd90;
      dcos = (dq >= 10'd360) ? 9'(dq - 10'd360) : dq[8:0];
      // plain mode: rotate by zero
      if (field_ff) begin
         cs_sel = otwdm_pkg::sin_deg(dcos);
         sn_sel = otwdm_pkg::sin_deg(dsin);
      end else begin
         cs_sel = otwdm_pkg::Q15_ONE;
         sn_sel = '0;
      end
   end

   // ---------------------------------------------------------------- rotator
   logic signed [otwdm_pkg::ROT_W-1:0] rx, ry;

   otwdm_rot u_rot (
      .clock (clock),
      .reset (reset),
      .start (rot_start),
      .cx    (cx_ff),
      .cy    (cy_ff),
      .cs    (cs_sel),
      .sn    (sn_sel),
      .x     (rx),
      .y     (ry),
      .done  (rot_done)
   );

   // ---------------------------------------------------------------- bound and dead-band checks
   logic signed [otwdm_pkg::LIM_W-1:0] rxe, rye;
   logic                               xz_in, yz_in, near;
   logic signed [otwdm_pkg::NUM_W-1:0] yk_in;

   always_comb begin
      rxe = otwdm_pkg::LIM_W'(rx);
      rye = otwdm_pkg::LIM_W'(ry);
      // drop an axis that leaves the field or is below half a unit
      xz_in = (rxe < limxlo_ff) || (rxe > limxhi_ff)
              || ((rx > otwdm_pkg::SPEED_HALF_NEG) && (rx < otwdm_pkg::SPEED_HALF));
      yz_in = (rye < limylo_ff) || (rye > limyhi_ff)
              || ((ry > otwdm_pkg::SPEED_HALF_NEG) && (ry < otwdm_pkg::SPEED_HALF));
      near  = xz_in && yz_in
              && (t_ff > otwdm_pkg::TURN_DEAD_NEG) && (t_ff < otwdm_pkg::TURN_DEAD);
      yk_in = otwdm_pkg::NUM_W'(ry) * otwdm_pkg::YK_SCALE;
   end

   // ---------------------------------------------------------------- wheel numerators
   logic signed [otwdm_pkg::NUM_W-1:0] xm, ykm, tq, a1, a2;
   logic signed [otwdm_pkg::NUM_W-1:0] num [otwdm_pkg::WHEELS];

   always_comb begin
      xm  = xz_ff ? '0 : otwdm_pkg::NUM_W'(rx);
      ykm = yz_ff ? '0 : yk_ff;
      tq  = otwdm_pkg::NUM_W'(t_ff) <<< otwdm_pkg::Q15_SHIFT;
      a1  = (xm <<< 1) + tq;
      a2  = tq - xm;
      num[0] = a1 <<< otwdm_pkg::NUM_SHIFT;
      num[1] = (a2 <<< otwdm_pkg::NUM_SHIFT) + ykm;
      num[2] = (a2 <<< otwdm_pkg::NUM_SHIFT) - ykm;
   end

   // ---------------------------------------------------------------- gain multiply and scale
   logic signed [otwdm_pkg::PROD_W-1:0]  prod  [otwdm_pkg::WHEELS];
   logic signed [otwdm_pkg::WHEEL_W-1:0] wheel [otwdm_pkg::WHEELS];

   otwdm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .gain  (otwdm_pkg::ramp_gain(step_ff)),
      .num   (num),
      .prod  (prod),
      .done  (mul_done)
   );

   for (genvar l = 0; l < otwdm_pkg::WHEELS; l++) begin : g_rnd
      otwdm_rnd u_rnd (
         .clock (clock),
         .take  (rnd_take),
         .prod  (prod[l]),
         .wheel (wheel[l])
      );
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         otwdm_pkg::S_IDLE:  if (req_acc) state_in = otwdm_pkg::S_PREP;
         otwdm_pkg::S_PREP:  state_in = otwdm_pkg::S_ROT;
         otwdm_pkg::S_ROT:   if (rot_done) state_in = otwdm_pkg::S_JUDGE;
         otwdm_pkg::S_JUDGE: state_in = near ? otwdm_pkg::S_DONE : otwdm_pkg::S_NUM;
         otwdm_pkg::S_NUM:   state_in = otwdm_pkg::S_MUL;
         otwdm_pkg::S_MUL:   if (mul_done) state_in = otwdm_pkg::S_RND;
         otwdm_pkg::S_RND:   state_in = otwdm_pkg::S_DIV;
         otwdm_pkg::S_DIV:   state_in = otwdm_pkg::S_DONE;
         otwdm_pkg::S_DONE:  if (out_free) state_in = otwdm_pkg::S_IDLE;
         default:            state_in = otwdm_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- ramp step
   always_comb begin
      step_in = step_ff;
      if (req_acc) begin
         // advance the soft start until it is full, or set it full in field-oriented mode
         if (field_ff || step_ff >= otwdm_pkg::RAMP_STEPS) begin
            step_in = otwdm_pkg::RAMP_STEPS;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else if (judge && near) begin
         step_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= otwdm_pkg::S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         field_ff     <= 1'b0;
         xlo_ff       <= otwdm_pkg::X_LO_RESET;
         xhi_ff       <= otwdm_pkg::X_HI_RESET;
         ylo_ff       <= otwdm_pkg::Y_LO_RESET;
         yhi_ff       <= otwdm_pkg::Y_HI_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_acc) begin
            case (otwdm_pkg::csr_index_type'(csr_if.index))
               otwdm_pkg::CSR_FIELD_ORIENTED: field_ff <= csr_if.data[0];
               otwdm_pkg::CSR_X_LOWER:        xlo_ff   <= signed'(csr_if.data);
               otwdm_pkg::CSR_X_UPPER:        xhi_ff   <= signed'(csr_if.data);
               otwdm_pkg::CSR_Y_LOWER:        ylo_ff   <= signed'(csr_if.data);
               otwdm_pkg::CSR_Y_UPPER:        yhi_ff   <= signed'(csr_if.data);
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- data registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cx_ff   <= req_if.speed_x;
         cy_ff   <= req_if.speed_y;
         t_ff    <= req_if.speed_turn;
         h_ff    <= req_if.heading_deg;
         // distance from position to each bound
         dxlo_ff <= otwdm_pkg::DIFF_W'(xlo_ff) - otwdm_pkg::DIFF_W'(req_if.pos_x);
         dxhi_ff <= otwdm_pkg::DIFF_W'(xhi_ff) - otwdm_pkg::DIFF_W'(req_if.pos_x);
         dylo_ff <= otwdm_pkg::DIFF_W'(ylo_ff) - otwdm_pkg::DIFF_W'(req_if.pos_y);
         dyhi_ff <= otwdm_pkg::DIFF_W'(yhi_ff) - otwdm_pkg::DIFF_W'(req_if.pos_y);
      end
      if (rot_start) begin
         limxlo_ff <= otwdm_pkg::bound_limit(dxlo_ff);
         limxhi_ff <= otwdm_pkg::bound_limit(dxhi_ff);
         limylo_ff <= otwdm_pkg::bound_limit(dylo_ff);
         limyhi_ff <= otwdm_pkg::bound_limit(dyhi_ff);
      end
      if (judge) begin
         xz_ff <= xz_in;
         yz_ff <= yz_in;
         yk_ff <= yk_in;
      end
      if (judge && near) begin
         for (int l = 0; l < otwdm_pkg::WHEELS; l++) res_ff[l] <= '0;
         res_stop_ff <= 1'b1;
      end else if (load_res) begin
         for (int l = 0; l < otwdm_pkg::WHEELS; l++) res_ff[l] <= wheel[l];
         res_stop_ff <= 1'b0;
      end
      if (load_out) begin
         for (int l = 0; l < otwdm_pkg::WHEELS; l++) out_ff[l] <= res_ff[l];
         out_stop_ff <= res_stop_ff;
      end
   end

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_stop_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_stop_ff |-> out_ff[0] == '0 && out_ff[1] == '0 && out_ff[2] == '0)
      else $error("stopped word carries non-zero wheels");
   a_step_max : assert property (@(posedge clock) disable iff (reset)
      step_ff <= otwdm_pkg::RAMP_STEPS)
      else $error("ramp step beyond its end");
   a_rot_done : assert property (@(posedge clock) disable iff (reset)
      rot_done |-> state_ff == otwdm_pkg::S_ROT)
      else $error("rotator finished outside rotation");
   a_mul_done : assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == otwdm_pkg::S_MUL)
      else $error("multiplier finished outside multiply");
   a_accept_prep : assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == otwdm_pkg::S_PREP && !rot_done && !mul_done)
      else $error("accepted word did not start preparation");
`endif

endmodule
`default_nettype wire

### design/otwdm_rot.sv
// Bit-serial rotator: (x, y) = (cx*cs + cy*sn, cy*cs - cx*sn), one multiplier bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module otwdm_rot (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [otwdm_pkg::SPEED_W-1:0] cx,
   input  logic signed [otwdm_pkg::SPEED_W-1:0] cy,
   input  logic signed [otwdm_pkg::SIN_W-1:0]   cs,
   input  logic signed [otwdm_pkg::SIN_W-1:0]   sn,
   output logic signed [otwdm_pkg::ROT_W-1:0]   x,
   output logic signed [otwdm_pkg::ROT_W-1:0]   y,
   output logic done
);

   logic                                  run_ff, run_in;
   logic [otwdm_pkg::ROT_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [otwdm_pkg::SPEED_W-1:0]         mx_ff, my_ff;
   logic signed [otwdm_pkg::ROT_W-1:0]    mcs_ff, msn_ff;
   logic signed [otwdm_pkg::ROT_W-1:0]    accx_ff, accx_in, accy_ff, accy_in;
   logic signed [otwdm_pkg::ROT_W-1:0]    tx, ty;
   logic                                  last;

   assign last = cnt_ff == otwdm_pkg::ROT_CNT_W'(otwdm_pkg::SPEED_W - 1);
   assign done = run_ff && last;
   assign x    = accx_ff;
   assign y    = accy_ff;

   always_comb begin
      tx = (mx_ff[0] ? mcs_ff : '0) + (my_ff[0] ? msn_ff : '0);
      ty = (my_ff[0] ? mcs_ff : '0) - (mx_ff[0] ? msn_ff : '0);
      // sign bit of the multiplier weighs negative
      accx_in = last ? accx_ff - tx : accx_ff + tx;
      accy_in = last ? accy_ff - ty : accy_ff + ty;
   end

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mx_ff   <= cx;
         my_ff   <= cy;
         mcs_ff  <= otwdm_pkg::ROT_W'(cs);
         msn_ff  <= otwdm_pkg::ROT_W'(sn);
         accx_ff <= '0;
         accy_ff <= '0;
      end else if (run_ff) begin
         mx_ff   <= mx_ff >> 1;
         my_ff   <= my_ff >> 1;
         mcs_ff  <= mcs_ff <<< 1;
         msn_ff  <= msn_ff <<< 1;
         accx_ff <= accx_in;
         accy_ff <= accy_in;
      end
   end

endmodule
`default_nettype wire

### design/otwdm_mul.sv
// Bit-serial gain multiplier: three wheel numerators times the ramp gain, one gain bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module otwdm_mul (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [otwdm_pkg::GAIN_W-1:0]        gain,
   input  logic signed [otwdm_pkg::NUM_W-1:0]  num  [otwdm_pkg::WHEELS],
   output logic signed [otwdm_pkg::PROD_W-1:0] prod [otwdm_pkg::WHEELS],
   output logic done
);

   logic                                  run_ff, run_in;
   logic [otwdm_pkg::MUL_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [otwdm_pkg::GAIN_W-1:0]          g_ff;
   logic signed [otwdm_pkg::PROD_W-1:0]   mult_ff [otwdm_pkg::WHEELS];
   logic signed [otwdm_pkg::PROD_W-1:0]   acc_ff  [otwdm_pkg::WHEELS];
   logic signed [otwdm_pkg::PROD_W-1:0]   acc_in  [otwdm_pkg::WHEELS];
   logic                                  last;

   assign last = cnt_ff == otwdm_pkg::MUL_CNT_W'(otwdm_pkg::GAIN_W - 1);
   assign done = run_ff && last;

   always_comb begin
      for (int l = 0; l < otwdm_pkg::WHEELS; l++) begin
         acc_in[l] = g_ff[0] ? acc_ff[l] + mult_ff[l] : acc_ff[l];
         prod[l]   = acc_ff[l];
      end
   end

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         g_ff <= gain;
         for (int l = 0; l < otwdm_pkg::WHEELS; l++) begin
            mult_ff[l] <= otwdm_pkg::PROD_W'(num[l]);
            acc_ff[l]  <= '0;
         end
      end else if (run_ff) begin
         g_ff <= g_ff >> 1;
         for (int l = 0; l < otwdm_pkg::WHEELS; l++) begin
            mult_ff[l] <= mult_ff[l] <<< 1;
            acc_ff[l]  <= acc_in[l];
         end
      end
   end

endmodule
`default_nettype wire

### design/otwdm_rnd.sv
// Wheel scaler: round product / (3 * 2^46) half away from zero and saturate to 12 bits.
`timescale 1ns / 1ps
`default_nettype none
module otwdm_rnd (
   input  logic clock,
   input  logic take,
   input  logic signed [otwdm_pkg::PROD_W-1:0]  prod,
   output logic signed [otwdm_pkg::WHEEL_W-1:0] wheel
);

   logic [otwdm_pkg::PROD_W-1:0]  mag, biased;
   logic [otwdm_pkg::QUOT_W-1:0]  w_full;
   logic [otwdm_pkg::W_W-1:0]     w_ff;
   logic                          neg_ff, sat_ff;
   logic [otwdm_pkg::DQ_W-1:0]    qp;
   logic [otwdm_pkg::WHEEL_W-1:0] q;

   // first step: magnitude plus half divisor, then drop the power-of-two part
   always_comb begin
      mag    = prod[otwdm_pkg::PROD_W-1] ? otwdm_pkg::PROD_W'(-prod)
                                         : otwdm_pkg::PROD_W'(prod);
      biased = mag + otwdm_pkg::HALF_DIV;
      w_full = biased[otwdm_pkg::PROD_W-1:otwdm_pkg::DIV_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (take) begin
         neg_ff <= prod[otwdm_pkg::PROD_W-1];
         sat_ff <= w_full >= otwdm_pkg::SAT_QUOT;
         w_ff   <= w_full[otwdm_pkg::W_W-1:0];
      end
   end

   // second step: divide by three through the reciprocal, exact below the limit
   always_comb begin
      qp = otwdm_pkg::DQ_W'(w_ff) * otwdm_pkg::DQ_W'(otwdm_pkg::RECIP3);
      q  = qp[otwdm_pkg::RECIP3_SHIFT +: otwdm_pkg::WHEEL_W];
      if (sat_ff) begin
         wheel = neg_ff ? otwdm_pkg::WHEEL_MIN : otwdm_pkg::WHEEL_MAX;
      end else begin
         wheel = neg_ff ? -signed'(q) : signed'(q);
      end
   end

endmodule
`default_nettype wire
